@@ rtl/ipd_pkg.sv @@
// shared types, codes and default-state function for the instruction prefix decoder
`default_nettype none
package ipd_pkg;

  typedef enum logic [2:0] {
    TBL_B16 = 3'd0,
    TBL_B32 = 3'd1,
    TBL_B64 = 3'd2,
    TBL_E16 = 3'd3,
    TBL_E32 = 3'd4,
    TBL_E64 = 3'd5
  } ipd_table_t;

  typedef enum logic [1:0] {
    MODE_REAL = 2'd0,
    MODE_PROT = 2'd1,
    MODE_LONG = 2'd2
  } ipd_mode_t;

  typedef enum logic [1:0] {
    ASZ_16 = 2'd0,
    ASZ_32 = 2'd1,
    ASZ_64 = 2'd2
  } ipd_asz_t;

  localparam logic [7:0] BYTE_ESCAPE   = 8'h0F;
  localparam logic [7:0] BYTE_SEG_CS   = 8'h2E;
  localparam logic [7:0] BYTE_SEG_DS   = 8'h3E;
  localparam logic [7:0] BYTE_REX_LO   = 8'h40;
  localparam logic [7:0] BYTE_REX_W_LO = 8'h48;
  localparam logic [7:0] BYTE_REX_HI   = 8'h4F;
  localparam logic [7:0] BYTE_OPSIZE   = 8'h66;
  localparam logic [7:0] BYTE_ADSIZE   = 8'h67;
  localparam logic [7:0] BYTE_REP      = 8'hF3;
  localparam logic [7:0] BYTE_WAIT     = 8'h9B;

  localparam int unsigned DATA_W = 24;

  typedef struct packed {
    ipd_table_t table_sel;
    logic       escape;
    logic       rex_plain;
    logic       rex_r;
    logic       rex_x;
    logic       rex_b;
    logic       wide;
    ipd_asz_t   addr;
    logic       seg_code;
    logic       rep;
    logic       fwait;
    logic       opsize;
  } ipd_state_t;

  // mode code three behaves as real mode
  function automatic ipd_mode_t eff_mode(input logic [1:0] mode);
    ipd_mode_t m;
    case (mode)
      2'd1:    m = MODE_PROT;
      2'd2:    m = MODE_LONG;
      default: m = MODE_REAL;
    endcase
    return m;
  endfunction

  function automatic ipd_state_t state_defaults(input ipd_mode_t m);
    ipd_state_t s;
    s           = '0;
    s.table_sel = (m == MODE_REAL) ? TBL_B16 : TBL_B32;
    s.wide      = (m == MODE_LONG);
    case (m)
      MODE_PROT: s.addr = ASZ_32;
      MODE_LONG: s.addr = ASZ_64;
      default:   s.addr = ASZ_16;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ rtl/instruction_prefix_decoder.sv @@
// top level of the instruction prefix decoder: state, handshake and result register
`default_nettype none
// Takes one instruction byte per beat on the s_ side and gives one decoded record on the m_ side
// for each opcode byte; prefix bytes only update the held prefix state. The prefix state
// register feeds a small combinational update and the record lands in
// an output register, so a byte is accepted every cycle while the output register is empty or
// being taken. cfg_we loads cpu_mode and resets the prefix state to the defaults for that mode;
// write it only while no byte is in flight.
module instruction_prefix_decoder
  import ipd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata,   // cpu_mode
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,     // instr_byte
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // opcode_byte[7:0], table_select[10:8], rex_seen, rex_reg_ext, rex_index_ext,
  // rex_base_ext, operand_wide, address_size[17:16], segment_is_code, repeat_prefix,
  // wait_prefix, size_override_seen, zero pad
  output logic [DATA_W-1:0]      m_tdata
);

  logic [1:0] cpu_mode;
  ipd_state_t state;
  ipd_state_t state_next;
  ipd_mode_t  mode;
  logic       is_opcode;
  logic       in_beat;

  assign mode     = eff_mode(cpu_mode);
  assign s_tready = !m_tvalid || m_tready;
  assign in_beat  = s_tvalid && s_tready;

  ipd_step u_step (
    .state      (state),
    .mode       (mode),
    .instr_byte (s_tdata),
    .state_next (state_next),
    .is_opcode  (is_opcode)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_mode <= 2'd0;
      state    <= state_defaults(MODE_REAL);
      m_tvalid <= 1'b0;
    end else begin
      if (in_beat && is_opcode && !cfg_we) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        cpu_mode <= cfg_wdata;
        state    <= state_defaults(eff_mode(cfg_wdata));
      end else if (in_beat) begin
        if (is_opcode) begin
          state <= state_defaults(mode);
        end else begin
          state <= state_next;
        end
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat && is_opcode) begin
      m_tdata <= {2'b00, state.opsize, state.fwait, state.rep, state.seg_code,
                  state.addr, state.wide, state.rex_b, state.rex_x, state.rex_r,
                  state.rex_plain, state.table_sel, s_tdata};
    end
  end

endmodule
`default_nettype wire

@@ rtl/ipd_step.sv @@
// per-byte prefix update: classifies one byte and computes the next prefix state
`default_nettype none
module ipd_step
  import ipd_pkg::*;
(
  input  wire ipd_state_t state,
  input  wire ipd_mode_t  mode,
  input  wire logic [7:0] instr_byte,
  output ipd_state_t      state_next,
  output logic            is_opcode
);

  logic is_rex;

  assign is_rex = (instr_byte >= BYTE_REX_LO) && (instr_byte <= BYTE_REX_HI)
                  && (mode == MODE_LONG);

  always_comb begin
    state_next = state;
    is_opcode  = 1'b0;
    if (state.escape) begin
      // byte after the escape always ends the instruction
      is_opcode = 1'b1;
    end else if (instr_byte == BYTE_ESCAPE) begin
      case (mode)
        MODE_PROT: state_next.table_sel = TBL_E32;
        MODE_LONG: state_next.table_sel = (state.table_sel == TBL_B64) ? TBL_E64 : TBL_E32;
        default:   state_next.table_sel = TBL_E16;
      endcase
      state_next.escape = 1'b1;
    end else if (instr_byte == BYTE_SEG_CS) begin
      state_next.seg_code = 1'b1;
    end else if (instr_byte == BYTE_SEG_DS) begin
      state_next.seg_code = 1'b0;
    end else if (is_rex) begin
      state_next.rex_r = state.rex_r | instr_byte[2];
      state_next.rex_x = state.rex_x | instr_byte[1];
      state_next.rex_b = state.rex_b | instr_byte[0];
      if (instr_byte == BYTE_REX_LO) begin
        state_next.rex_plain = 1'b1;
      end
      if (instr_byte >= BYTE_REX_W_LO) begin
        state_next.wide      = 1'b1;
        state_next.table_sel = (state.table_sel == TBL_E32) ? TBL_E64 : TBL_B64;
      end
    end else if (instr_byte == BYTE_OPSIZE) begin
      case (state.table_sel)
        TBL_B16: state_next.table_sel = TBL_B32;
        TBL_E16: state_next.table_sel = TBL_E32;
        TBL_B32: state_next.table_sel = TBL_B16;
        default: state_next.table_sel = TBL_E32;
      endcase
      state_next.opsize = 1'b1;
    end else if (instr_byte == BYTE_ADSIZE) begin
      // sixty-four and sixteen both go to thirty-two
      state_next.addr = (state.addr == ASZ_32) ? ASZ_16 : ASZ_32;
    end else if (instr_byte == BYTE_REP) begin
      state_next.rep = 1'b1;
    end else if (instr_byte == BYTE_WAIT) begin
      state_next.fwait = 1'b1;
    end else begin
      is_opcode = 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ test/tb_instruction_prefix_decoder.sv @@
// testbench for the instruction prefix decoder: random and directed byte streams checked against a predictor
`timescale 1ns / 100ps
module tb_instruction_prefix_decoder;
  import ipd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned BYTES_PER_SET = 255;
  localparam logic [1:0]  MODE_RESERVED = 2'd3;

  typedef struct {
    logic [7:0] opcode;
    ipd_table_t tbl;
    logic       rex_plain;
    logic       rex_r;
    logic       rex_x;
    logic       rex_b;
    logic       wide;
    ipd_asz_t   asz;
    logic       seg_code;
    logic       rep;
    logic       fwait;
    logic       opsize;
  } decode_rec_t;

  class decode_scoreboard;
    decode_rec_t pending_records[$];
    ipd_mode_t   mode;
    ipd_table_t  tbl;
    ipd_asz_t    asz;
    logic        escaped, rex_plain, rex_r, rex_x, rex_b, wide;
    logic        seg_code, rep, fwait, opsize;
    int unsigned errors;
    int unsigned bytes_taken;
    int unsigned records_checked;

    function new();
      errors = 0;
      bytes_taken = 0;
      records_checked = 0;
      load_mode(MODE_REAL);
    endfunction

    // any mode load drops the prefixes gathered so far
    function void load_mode(logic [1:0] code);
      if (code == MODE_PROT) begin
        mode = MODE_PROT;
      end else if (code == MODE_LONG) begin
        mode = MODE_LONG;
      end else begin
        mode = MODE_REAL;
      end
      if (mode == MODE_REAL) begin
        tbl = TBL_B16;
        asz = ASZ_16;
      end else if (mode == MODE_PROT) begin
        tbl = TBL_B32;
        asz = ASZ_32;
      end else begin
        tbl = TBL_B32;
        asz = ASZ_64;
      end
      wide = (mode == MODE_LONG);
      escaped = 1'b0;
      rex_plain = 1'b0;
      rex_r = 1'b0;
      rex_x = 1'b0;
      rex_b = 1'b0;
      seg_code = 1'b0;
      rep = 1'b0;
      fwait = 1'b0;
      opsize = 1'b0;
    endfunction

    function void take_byte(logic [7:0] b);
      decode_rec_t r;
      logic        is_prefix;
      bytes_taken++;
      is_prefix = 1'b1;
      if (escaped) begin
        is_prefix = 1'b0;
      end else if (b == BYTE_ESCAPE) begin
        if (mode == MODE_REAL) begin
          tbl = TBL_E16;
        end else if (mode == MODE_PROT) begin
          tbl = TBL_E32;
        end else if (tbl == TBL_B64) begin
          tbl = TBL_E64;
        end else begin
          tbl = TBL_E32;
        end
        escaped = 1'b1;
      end else if (b == BYTE_SEG_CS) begin
        seg_code = 1'b1;
      end else if (b == BYTE_SEG_DS) begin
        seg_code = 1'b0;
      end else if (b >= BYTE_REX_LO && b <= BYTE_REX_HI && mode == MODE_LONG) begin
        rex_r = rex_r | b[2];
        rex_x = rex_x | b[1];
        rex_b = rex_b | b[0];
        if (b == BYTE_REX_LO) rex_plain = 1'b1;
        if (b >= BYTE_REX_W_LO) begin
          wide = 1'b1;
          if (tbl == TBL_E32) begin
            tbl = TBL_E64;
          end else begin
            tbl = TBL_B64;
          end
        end
      end else if (b == BYTE_OPSIZE) begin
        case (tbl)
          TBL_B16: tbl = TBL_B32;
          TBL_E16: tbl = TBL_E32;
          TBL_B32: tbl = TBL_B16;
          default: tbl = TBL_E32;
        endcase
        opsize = 1'b1;
      end else if (b == BYTE_ADSIZE) begin
        if (asz == ASZ_32) begin
          asz = ASZ_16;
        end else begin
          asz = ASZ_32;
        end
      end else if (b == BYTE_REP) begin
        rep = 1'b1;
      end else if (b == BYTE_WAIT) begin
        fwait = 1'b1;
      end else begin
        is_prefix = 1'b0;
      end
      if (!is_prefix) begin
        r.opcode = b;
        r.tbl = tbl;
        r.rex_plain = rex_plain;
        r.rex_r = rex_r;
        r.rex_x = rex_x;
        r.rex_b = rex_b;
        r.wide = wide;
        r.asz = asz;
        r.seg_code = seg_code;
        r.rep = rep;
        r.fwait = fwait;
        r.opsize = opsize;
        pending_records.push_back(r);
        load_mode(mode);
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task compare_field(string name, int unsigned exp, int unsigned got);
      if (exp != got) begin
        report_mismatch($sformatf("record %0d field %s: expected %0h got %0h",
                                  records_checked, name, exp, got));
      end
    endtask

    task check_record(logic [DATA_W-1:0] d);
      decode_rec_t e;
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("unexpected record %0h", d));
      end else begin
        e = pending_records.pop_front();
        compare_field("opcode_byte", e.opcode, d[7:0]);
        compare_field("table_select", e.tbl, d[10:8]);
        compare_field("rex_seen", e.rex_plain, d[11]);
        compare_field("rex_reg_ext", e.rex_r, d[12]);
        compare_field("rex_index_ext", e.rex_x, d[13]);
        compare_field("rex_base_ext", e.rex_b, d[14]);
        compare_field("operand_wide", e.wide, d[15]);
        compare_field("address_size", e.asz, d[17:16]);
        compare_field("segment_is_code", e.seg_code, d[18]);
        compare_field("repeat_prefix", e.rep, d[19]);
        compare_field("wait_prefix", e.fwait, d[20]);
        compare_field("size_override_seen", e.opsize, d[21]);
        records_checked++;
      end
    endtask

    task check_leftovers();
      if (pending_records.size() != 0) begin
        report_mismatch($sformatf("%0d records never arrived", pending_records.size()));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;

  decode_scoreboard sb = new();
  int unsigned      cycles = 0;
  int unsigned      stall_left = 0;
  int unsigned      mode_writes = 0;
  logic             quiet = 1'b0;

  instruction_prefix_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none during quiet stretches
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 256 == 0) quiet <= ($urandom_range(0, 3) == 0);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check each accepted beat, stall at random
  always @(posedge clk) begin
    int unsigned n;
    if (!rst && m_tvalid && m_tready) sb.check_record(m_tdata);
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      n = idle_len();
      if (n > 0) begin
        m_tready <= 1'b0;
        stall_left <= n - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task send_byte(logic [7:0] b);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sb.take_byte(b);
  endtask

  // stop sending and let every pending record come out
  task drain();
    s_tvalid <= 1'b0;
    while (sb.pending_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_mode(logic [1:0] code);
    cfg_we <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_mode(code);
    mode_writes++;
  endtask

  function automatic logic [7:0] random_prefix();
    case ($urandom_range(0, 7))
      0: return BYTE_SEG_CS;
      1: return BYTE_SEG_DS;
      2: return BYTE_OPSIZE;
      3: return BYTE_ADSIZE;
      4: return BYTE_REP;
      5: return BYTE_WAIT;
      default: return BYTE_REX_LO + 8'($urandom_range(0, 15));
    endcase
  endfunction

  // a prefix run with random content, an optional escape and an opcode;
  // now and then plain noise instead
  task send_instruction();
    int unsigned n;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      n = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 4) : $urandom_range(5, 20);
      repeat (n) send_byte(random_prefix());
      if ($urandom_range(0, 99) < 40) send_byte(BYTE_ESCAPE);
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task send_directed();
    logic [7:0] seq[$];
    seq = '{8'h00, 8'hFF,
            BYTE_OPSIZE, BYTE_ADSIZE, BYTE_SEG_CS, BYTE_REP, BYTE_WAIT, BYTE_REX_LO, 8'h90,
            BYTE_REX_W_LO, BYTE_ESCAPE, BYTE_OPSIZE,
            BYTE_SEG_DS, 8'h45, BYTE_OPSIZE, BYTE_ESCAPE, 8'h05,
            BYTE_REX_HI, BYTE_OPSIZE, BYTE_ADSIZE, BYTE_ADSIZE, 8'h01,
            BYTE_ESCAPE, BYTE_ESCAPE};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  initial begin
    logic [1:0]  set_modes[7];
    int unsigned start_bytes;
    logic        paused;
    set_modes = '{MODE_LONG, MODE_REAL, MODE_PROT, MODE_RESERVED, MODE_LONG, MODE_PROT,
                  MODE_REAL};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (set_modes[p]) begin
      drain();
      write_mode(set_modes[p]);
      if (p == 0) send_directed();
      start_bytes = sb.bytes_taken;
      paused = 1'b0;
      while (sb.bytes_taken - start_bytes < BYTES_PER_SET) begin
        if (!paused && sb.bytes_taken - start_bytes > BYTES_PER_SET / 2) begin
          drain();
          paused = 1'b1;
        end
        send_instruction();
      end
      // leave a few prefixes hanging so the mode write has to drop them
      repeat ($urandom_range(0, 2)) send_byte(random_prefix());
    end
    drain();
    sb.check_leftovers();
    $display("checked %0d records from %0d bytes over %0d mode writes, all four mode codes",
             sb.records_checked, sb.bytes_taken, mode_writes);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
